FILE: rtl/rcc_pkg.sv
// ----------------------------------------------------------------------------
// rcc_pkg
// shared types and constants of the 3x3 rgb convolution core
// ----------------------------------------------------------------------------
package rcc_pkg;
    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = $clog2(MaxHeight);
    localparam int NumPlanes = 3;
    localparam int PixW      = 8 * NumPlanes;
    localparam int SumW      = 16;
    localparam int QuoW      = 17;

    typedef enum logic [2:0] {
        CFG_WIDTH  = 3'd0,
        CFG_HEIGHT = 3'd1,
        CFG_TOP    = 3'd2,
        CFG_MID    = 3'd3,
        CFG_BOT    = 3'd4,
        CFG_DIV    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [7:0]      clamp;
        logic            busy;
    } t_lane_res;
endpackage

FILE: rtl/rcc_ram.sv
// ----------------------------------------------------------------------------
// rcc_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module rcc_ram #(
    parameter int Width = 24,
    parameter int Depth = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_addr,
    input  logic [Width-1:0]         i_wdata,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr] <= i_wdata;
        o_rdata <= r_mem[i_addr];
    end
endmodule

FILE: rtl/rcc_lane.sv
// ----------------------------------------------------------------------------
// rcc_lane
// one color plane: 3x3 multiply-accumulate, signed division and clamp
// ----------------------------------------------------------------------------
module rcc_lane
    import rcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [71:0] i_pix,
    input  logic [71:0] i_coef,
    input  logic [6:0]  i_div,
    output t_lane_res   o_res
);
    logic signed [SumW-1:0] r_prod [9];
    logic                   r_mul_v;
    logic [QuoW-1:0]        r_rem, n_rem;
    logic [SumW-1:0]        r_mag;
    logic [SumW-1:0]        r_quo;
    logic                   r_neg;
    logic [4:0]             r_cnt;
    logic                   r_busy;
    logic [7:0]             lane_clamp;
    logic signed [SumW-1:0] sum;
    logic [6:0]             d;

    assign d = (i_div == 7'd0) ? 7'd1 : i_div;

    always_comb begin
        sum = '0;
        for (int k = 0; k < 9; k++) sum = sum + r_prod[k];
    end
    assign n_rem = {r_rem[QuoW-2:0], r_mag[SumW-1]};

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 9; k++)
            r_prod[k] <= SumW'($signed({1'b0, i_pix[8*k +: 8]}) * $signed(i_coef[8*k +: 8]));
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
            r_busy  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_mul_v <= i_start;
            if (r_mul_v) begin
                r_neg  <= sum[SumW-1];
                r_mag  <= sum[SumW-1] ? SumW'(-sum) : sum;
                r_rem  <= '0;
                r_cnt  <= 5'd16;
                r_busy <= 1'b1;
            end else if (r_cnt != 5'd0) begin
                r_mag <= {r_mag[SumW-2:0], 1'b0};
                if (n_rem >= QuoW'(d)) begin
                    r_rem <= n_rem - QuoW'(d);
                    r_quo <= {r_quo[SumW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_quo <= {r_quo[SumW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 5'd1;
            end else begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_neg || r_quo == '0) lane_clamp = 8'd0;
        else if (r_quo > 16'd255) lane_clamp = 8'd255;
        else lane_clamp = r_quo[7:0];
    end
    assign o_res.clamp = lane_clamp;
    assign o_res.busy  = r_busy | r_mul_v | i_start;
endmodule

FILE: rtl/rgb_convolution_3x3_clamped_core.sv
// ----------------------------------------------------------------------------
// rgb_convolution_3x3_clamped_core
// 3x3 rgb convolution with divisor and clamp over a raster pixel stream
// ----------------------------------------------------------------------------
// One pixel is taken per beat in raster order; three plane lanes filter the
// window side by side. An interior pixel raises o_valid after one multiply
// stage, a step to sum and load the dividers, 16 restoring divider steps per
// lane, and the lanes going idle, the state machine following and the output
// register loading; the next beat can be taken once that register is loaded.
// A border pixel frees the input after the multiply state and yields no
// result. A waiting result holds the input off only once the next result is
// ready behind it. Writing width or height restarts the frame; the user must
// write registers only while no pixel is in flight; the block does not enforce it.
module rgb_convolution_3x3_clamped_core
    import rcc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_pixel_plane0,
    input  logic [7:0]  i_pixel_plane1,
    input  logic [7:0]  i_pixel_plane2,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_plane0,
    output logic [7:0]  o_out_plane1,
    output logic [7:0]  o_out_plane2,
    output logic [9:0]  o_out_row,
    output logic [9:0]  o_out_col,
    output logic        o_frame_end
);
    t_state r_state, n_state;
    logic [10:0] r_w, r_h;
    logic [23:0] r_ct, r_cm, r_cb;
    logic [6:0]  r_div;
    logic [RowW-1:0] r_row;
    logic [ColW-1:0] r_col;
    logic [PixW-1:0] r_px, r_win [6];
    logic [PixW-1:0] top, mid;
    logic [10:0] w, h;
    logic        r_emit, r_fe, r_pfe;
    logic [9:0]  r_orow, r_ocol, r_prow, r_pcol;
    logic        r_ovalid;
    logic [7:0]  r_o [3];
    logic        start, we, acc, out_go;
    t_lane_res   lres [3];

    assign w = (r_w < 11'd3) ? 11'd3 : (r_w > 11'(MaxWidth)) ? 11'(MaxWidth) : r_w;
    assign h = (r_h < 11'd3) ? 11'd3 : (r_h > 11'(MaxHeight)) ? 11'(MaxHeight) : r_h;

    assign acc     = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign we = (r_state == ST_MUL);
    assign out_go = (r_state == ST_OUT) && (!r_ovalid || !i_stall);

    rcc_ram #(.Width(PixW), .Depth(MaxWidth)) u_old (
        .i_clk(i_clk), .i_we(we), .i_addr(r_col), .i_wdata(mid), .o_rdata(top));
    rcc_ram #(.Width(PixW), .Depth(MaxWidth)) u_new (
        .i_clk(i_clk), .i_we(we), .i_addr(r_col), .i_wdata(r_px), .o_rdata(mid));

    assign start = we && r_emit;

    for (genvar p = 0; p < NumPlanes; p++) begin : g_lane
        logic [71:0] pix, coef;
        logic [71:0] pix_o;
        assign pix = {r_px[8*p +: 8], mid[8*p +: 8], top[8*p +: 8],
                      r_win[5][8*p +: 8], r_win[4][8*p +: 8], r_win[3][8*p +: 8],
                      r_win[2][8*p +: 8], r_win[1][8*p +: 8], r_win[0][8*p +: 8]};
        // order k = row*3+col: top row, middle row, bottom row
        assign coef = {r_cb, r_cm, r_ct};
        assign pix_o = {pix[71:64], pix[47:40], pix[23:16],
                        pix[63:56], pix[39:32], pix[15:8],
                        pix[55:48], pix[31:24], pix[7:0]};
        rcc_lane u_lane (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start),
            .i_pix(pix_o), .i_coef(coef), .i_div(r_div), .o_res(lres[p]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (acc) n_state = ST_MUL;
            ST_MUL:  n_state = r_emit ? ST_DIV : ST_IDLE;
            ST_DIV:  if (!lres[0].busy) n_state = ST_OUT;
            ST_OUT:  if (out_go) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_px <= {i_pixel_plane2, i_pixel_plane1, i_pixel_plane0};
        if (!i_rst_n) begin
            r_w <= 11'd1024; r_h <= 11'd1024;
            r_ct <= '0; r_cm <= 24'h000100; r_cb <= '0; r_div <= 7'd1;
            r_row <= '0; r_col <= '0; r_ovalid <= 1'b0; r_emit <= 1'b0;
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  begin r_w <= i_cfg_data[10:0]; r_row <= '0; r_col <= '0; end
                    CFG_HEIGHT: begin r_h <= i_cfg_data[10:0]; r_row <= '0; r_col <= '0; end
                    CFG_TOP:    r_ct  <= i_cfg_data;
                    CFG_MID:    r_cm  <= i_cfg_data;
                    CFG_BOT:    r_cb  <= i_cfg_data;
                    CFG_DIV:    r_div <= i_cfg_data[6:0];
                    default:    ;
                endcase
            end
            if (acc) begin
                r_emit <= (r_row >= RowW'(2)) && (r_col >= ColW'(2));
                r_prow <= 10'(r_row - RowW'(1));
                r_pcol <= 10'(r_col - ColW'(1));
                r_pfe  <= (11'(r_row) == h - 11'd1) && (11'(r_col) == w - 11'd1);
            end
            if (we) begin
                r_win[0] <= r_win[3]; r_win[1] <= r_win[4]; r_win[2] <= r_win[5];
                r_win[3] <= top; r_win[4] <= mid; r_win[5] <= r_px;
                if (11'(r_col) + 11'd1 >= w) begin
                    r_col <= '0;
                    r_row <= (11'(r_row) + 11'd1 >= h) ? '0 : RowW'(r_row + RowW'(1));
                end else begin
                    r_col <= ColW'(r_col + ColW'(1));
                end
            end
            if (out_go) begin
                r_ovalid <= 1'b1;
                r_orow   <= r_prow;
                r_ocol   <= r_pcol;
                r_fe     <= r_pfe;
                for (int p = 0; p < 3; p++) r_o[p] <= lres[p].clamp;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_ovalid;
    assign o_out_plane0 = r_o[0];
    assign o_out_plane1 = r_o[1];
    assign o_out_plane2 = r_o[2];
    assign o_out_row    = r_orow;
    assign o_out_col    = r_ocol;
    assign o_frame_end  = r_fe;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !acc) else $error("accept while busy");
    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |=> r_ovalid) else $error("result lost");
    a_lanes_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lres[0].busy == lres[2].busy) else $error("lanes out of step");
endmodule
